[rtl/core/sbc_pkg.sv]
// sbc_pkg: shared widths, codes and types for the sphere/box classifier
package sbc_pkg;

  localparam int COORD_BITS = 16;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int RSQ_BITS   = 2 * RAD_BITS;

  localparam logic [1:0] REL_OUTSIDE    = 2'd0;
  localparam logic [1:0] REL_INTERSECTS = 2'd1;
  localparam logic [1:0] REL_INSIDE     = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        dist_t;
  typedef logic [SQ_BITS-1:0]           sq_t;

  typedef struct packed {
    sq_t slab_sq;
    sq_t far_sq;
  } axis_sq_t;

endpackage

[rtl/core/sbc_axis.sv]
// sbc_axis: per-axis slab and farthest-corner distances, squared over two stages
module sbc_axis (
  input  logic              clk,
  input  sbc_pkg::coord_t   center,
  input  sbc_pkg::coord_t   box_min,
  input  sbc_pkg::coord_t   box_max,
  output sbc_pkg::axis_sq_t sq
);

  logic signed [sbc_pkg::COORD_BITS:0] diff_mn;
  logic signed [sbc_pkg::COORD_BITS:0] diff_mx;
  logic signed [sbc_pkg::COORD_BITS:0] abs_mn;
  logic signed [sbc_pkg::COORD_BITS:0] abs_mx;
  sbc_pkg::dist_t dmn;
  sbc_pkg::dist_t dmx;
  sbc_pkg::dist_t d_slab_next;
  sbc_pkg::dist_t d_far_next;
  sbc_pkg::dist_t d_slab;
  sbc_pkg::dist_t d_far;

  assign diff_mn = {box_min[sbc_pkg::COORD_BITS-1], box_min}
                 - {center[sbc_pkg::COORD_BITS-1], center};
  assign diff_mx = {box_max[sbc_pkg::COORD_BITS-1], box_max}
                 - {center[sbc_pkg::COORD_BITS-1], center};
  assign abs_mn  = diff_mn[sbc_pkg::COORD_BITS] ? -diff_mn : diff_mn;
  assign abs_mx  = diff_mx[sbc_pkg::COORD_BITS] ? -diff_mx : diff_mx;
  assign dmn     = abs_mn[sbc_pkg::COORD_BITS-1:0];
  assign dmx     = abs_mx[sbc_pkg::COORD_BITS-1:0];

  always_comb begin
    priority if (center < box_min) begin
      d_slab_next = dmn;
    end else if (center > box_max) begin
      d_slab_next = dmx;
    end else begin
      d_slab_next = '0;
    end
    d_far_next = (dmn > dmx) ? dmn : dmx;
  end

  always_ff @(posedge clk) begin
    d_slab     <= d_slab_next;
    d_far      <= d_far_next;
    sq.slab_sq <= sbc_pkg::SQ_BITS'(d_slab) * sbc_pkg::SQ_BITS'(d_slab);
    sq.far_sq  <= sbc_pkg::SQ_BITS'(d_far) * sbc_pkg::SQ_BITS'(d_far);
  end

endmodule

[rtl/core/sphere_box_classify.sv]
// sphere_box_classify: top level of the sphere versus axis-aligned box classifier
// A request is taken at every clock edge where start is high and busy is low; busy is
// high only while rst is held, so one request per cycle streams through. Each request
// gives its relation on the cycle where done is high, after distances in the first
// stage, squaring multipliers in the second, the three-axis sums and the two compares
// in the third. The receiver cannot hold results off.
module sphere_box_classify (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sbc_pkg::COORD_BITS-1:0] center_x,
  input  logic [sbc_pkg::COORD_BITS-1:0] center_y,
  input  logic [sbc_pkg::COORD_BITS-1:0] center_z,
  input  logic [sbc_pkg::RAD_BITS-1:0]   sphere_radius,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_min_x,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_min_y,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_min_z,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_max_x,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_max_y,
  input  logic [sbc_pkg::COORD_BITS-1:0] box_max_z,
  output logic                          done,
  output logic [1:0]                    relation
);

  logic                           v1;
  logic                           v2;
  logic [sbc_pkg::RAD_BITS-1:0]   rad1;
  logic [sbc_pkg::RSQ_BITS-1:0]   rsq2;
  sbc_pkg::axis_sq_t              sq_x;
  sbc_pkg::axis_sq_t              sq_y;
  sbc_pkg::axis_sq_t              sq_z;
  logic [sbc_pkg::SUM_BITS-1:0]   slab_sum;
  logic [sbc_pkg::SUM_BITS-1:0]   far_sum;
  logic [sbc_pkg::SUM_BITS-1:0]   rsq_ext;
  logic [1:0]                     relation_next;

  assign busy = rst;

  sbc_axis u_axis_x (
    .clk     (clk),
    .center  (sbc_pkg::coord_t'(center_x)),
    .box_min (sbc_pkg::coord_t'(box_min_x)),
    .box_max (sbc_pkg::coord_t'(box_max_x)),
    .sq      (sq_x)
  );

  sbc_axis u_axis_y (
    .clk     (clk),
    .center  (sbc_pkg::coord_t'(center_y)),
    .box_min (sbc_pkg::coord_t'(box_min_y)),
    .box_max (sbc_pkg::coord_t'(box_max_y)),
    .sq      (sq_y)
  );

  sbc_axis u_axis_z (
    .clk     (clk),
    .center  (sbc_pkg::coord_t'(center_z)),
    .box_min (sbc_pkg::coord_t'(box_min_z)),
    .box_max (sbc_pkg::coord_t'(box_max_z)),
    .sq      (sq_z)
  );

  assign slab_sum = sbc_pkg::SUM_BITS'(sq_x.slab_sq) + sbc_pkg::SUM_BITS'(sq_y.slab_sq)
                  + sbc_pkg::SUM_BITS'(sq_z.slab_sq);
  assign far_sum  = sbc_pkg::SUM_BITS'(sq_x.far_sq) + sbc_pkg::SUM_BITS'(sq_y.far_sq)
                  + sbc_pkg::SUM_BITS'(sq_z.far_sq);
  assign rsq_ext  = sbc_pkg::SUM_BITS'(rsq2);

  always_comb begin
    priority if (slab_sum >= rsq_ext) begin
      relation_next = sbc_pkg::REL_OUTSIDE;
    end else if (far_sum >= rsq_ext) begin
      relation_next = sbc_pkg::REL_INTERSECTS;
    end else begin
      relation_next = sbc_pkg::REL_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      done <= v2;
    end
    rad1     <= sphere_radius;
    rsq2     <= sbc_pkg::RSQ_BITS'(rad1) * sbc_pkg::RSQ_BITS'(rad1);
    relation <= relation_next;
  end

  // every result traces back to an accepted request (start high while busy is low)
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching request");

  // only the three defined relation codes leave the block
  a_relation_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (relation == sbc_pkg::REL_OUTSIDE || relation == sbc_pkg::REL_INTERSECTS
              || relation == sbc_pkg::REL_INSIDE))
    else $error("undefined relation code");

  // a zero radius sphere is always outside
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (done && $past(sphere_radius == '0, 3)) |-> (relation == sbc_pkg::REL_OUTSIDE))
    else $error("zero radius not classified outside");

endmodule
